/* rtl/pidc_pkg.sv */
`timescale 1ns / 1ps

package pidc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [2:0] REG_OUT_MIN     = 3'd3;
	localparam logic [2:0] REG_OUT_MAX     = 3'd4;
	localparam logic [2:0] REG_PROP_ON_MEAS = 3'd5;
	localparam logic [2:0] REG_REVERSE     = 3'd6;

	// reset values
	localparam logic [15:0] PROP_GAIN_RST = 16'd256;
	localparam logic [15:0] OUT_MAX_RST   = 16'd25600;

	// item kind carried in tuser
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_MODE   = 1'b1;

	typedef struct packed {
		logic [15:0]        prop_gain;
		logic [15:0]        integ_gain;
		logic [15:0]        deriv_gain;
		logic signed [15:0] out_min;
		logic signed [15:0] out_max;
		logic               prop_on_measurement;
		logic               reverse_action;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic signed [15:0] measured;
		logic signed [15:0] setpoint;
		logic               auto_request;
	} item_t;

endpackage

/* rtl/pidc_cfg_regs.sv */
`timescale 1ns / 1ps

module pidc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output pidc_pkg::cfg_t     cfg
);

	pidc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain           <= pidc_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain          <= '0;
			cfg_q.deriv_gain          <= '0;
			cfg_q.out_min             <= '0;
			cfg_q.out_max             <= pidc_pkg::OUT_MAX_RST;
			cfg_q.prop_on_measurement <= 1'b0;
			cfg_q.reverse_action      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pidc_pkg::REG_PROP_GAIN:    cfg_q.prop_gain <= cfg_data;
				pidc_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain <= cfg_data;
				pidc_pkg::REG_DERIV_GAIN:   cfg_q.deriv_gain <= cfg_data;
				pidc_pkg::REG_OUT_MIN:      cfg_q.out_min <= cfg_data;
				pidc_pkg::REG_OUT_MAX:      cfg_q.out_max <= cfg_data;
				pidc_pkg::REG_PROP_ON_MEAS: cfg_q.prop_on_measurement <= cfg_data[0];
				pidc_pkg::REG_REVERSE:      cfg_q.reverse_action <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/pidc_core.sv */
`timescale 1ns / 1ps

module pidc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  pidc_pkg::cfg_t     cfg,
	input  logic               fire,
	input  pidc_pkg::item_t    item,
	output logic signed [15:0] drive,
	output logic               computed
);

	logic signed [15:0] integral_q;
	logic signed [15:0] prev_meas_q;
	logic signed [15:0] prev_drive_q;
	logic               auto_q;

	logic signed [16:0] err;
	logic signed [16:0] din;
	logic signed [16:0] kp_s;
	logic signed [16:0] ki_s;
	logic signed [16:0] kd_s;
	logic signed [33:0] kp_err;
	logic signed [33:0] kp_din;
	logic signed [33:0] ki_err;
	logic signed [33:0] kd_din;
	logic signed [35:0] acc_i;
	logic signed [35:0] acc_d;
	logic signed [15:0] integ_new;
	logic signed [15:0] drive_new;
	logic signed [15:0] integ_load;

	// Q.16 sum -> round half up to Q8.8 -> clamp (max wins when limits cross)
	function automatic logic signed [15:0] round_clamp(
		input logic signed [35:0] acc,
		input logic signed [15:0] lo,
		input logic signed [15:0] hi
	);
		logic signed [35:0] r;
		logic signed [35:0] lo_x;
		logic signed [35:0] hi_x;
		logic signed [15:0] res;
		r    = (acc + 36'sd128) >>> 8;
		lo_x = {{20{lo[15]}}, lo};
		hi_x = {{20{hi[15]}}, hi};
		if (r > hi_x)
			res = hi;
		else if (r < lo_x)
			res = lo;
		else
			res = r[15:0];
		return res;
	endfunction

	function automatic logic signed [16:0] signed_gain(
		input logic [15:0] g,
		input logic        rev
	);
		logic signed [16:0] mag;
		mag = {1'b0, g};
		return rev ? (17'sd0 - mag) : mag;
	endfunction

	function automatic logic signed [35:0] q16_of(input logic signed [15:0] v);
		return {{12{v[15]}}, v, 8'b0};
	endfunction

	function automatic logic signed [35:0] sx_prod(input logic signed [33:0] p);
		return {{2{p[33]}}, p};
	endfunction

	always_comb begin
		err  = {item.setpoint[15], item.setpoint} - {item.measured[15], item.measured};
		din  = {item.measured[15], item.measured} - {prev_meas_q[15], prev_meas_q};
		kp_s = signed_gain(cfg.prop_gain, cfg.reverse_action);
		ki_s = signed_gain(cfg.integ_gain, cfg.reverse_action);
		kd_s = signed_gain(cfg.deriv_gain, cfg.reverse_action);

		kp_err = kp_s * err;
		kp_din = kp_s * din;
		ki_err = ki_s * err;
		kd_din = kd_s * din;

		// integral update, P on measurement folds into it
		acc_i = q16_of(integral_q) + sx_prod(ki_err);
		if (cfg.prop_on_measurement)
			acc_i = acc_i - sx_prod(kp_din);
		integ_new = round_clamp(acc_i, cfg.out_min, cfg.out_max);

		acc_d = q16_of(integ_new) - sx_prod(kd_din);
		if (!cfg.prop_on_measurement)
			acc_d = acc_d + sx_prod(kp_err);
		drive_new = round_clamp(acc_d, cfg.out_min, cfg.out_max);

		// bumpless transfer: integral seeded from last drive
		integ_load = round_clamp(q16_of(prev_drive_q), cfg.out_min, cfg.out_max);

		computed = (item.func == pidc_pkg::FUNC_SAMPLE) && auto_q;
		drive    = computed ? drive_new : 16'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_meas_q  <= '0;
			prev_drive_q <= '0;
			auto_q       <= 1'b0;
		end else if (fire) begin
			if (item.func == pidc_pkg::FUNC_MODE) begin
				if (item.auto_request && !auto_q)
					integral_q <= integ_load;
				auto_q <= item.auto_request;
			end else if (auto_q) begin
				integral_q   <= integ_new;
				prev_drive_q <= drive_new;
				prev_meas_q  <= item.measured;
			end
		end
	end

endmodule

/* rtl/pid_controller_step.sv */
`timescale 1ns / 1ps

// discrete pid step with anti-windup clamping, all values signed q8.8
// input stream (s_axis_*): one word per sample or mode change; tuser is the
// kind (0 sample, 1 mode), tdata carries measured, setpoint, auto_request
// output stream (m_axis_*): exactly one word per input word; tdata is the
// clamped drive, tuser is set when a sample was processed in automatic mode
// (otherwise drive reads zero)
// config channel (cfg_*): register index and data, always ready; write only
// while no word is in flight
// a word accepted into the input register is computed from it and registered
// in the output register, from which it is offered on m_axis
// throughput: one word per cycle unless the receiver stalls; the integral
// feedback closes within the single combinational pass between the input
// register and the output register, so consecutive samples never wait on each other
// when the receiver stalls the output register holds its word and the input
// register still takes one more word; after that s_axis_tready drops
// reset clears the gains to their defaults, the integral, last measurement
// and last drive to zero, and selects manual mode

module pid_controller_step (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // measured[15:0], setpoint[31:16], auto_request[32], zero pad
	input  logic        s_axis_tuser,   // func

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // drive[15:0]
	output logic        m_axis_tuser,   // computed

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pidc_pkg::cfg_t  cfg;
	pidc_pkg::item_t item_s1;
	logic            valid_s1;
	logic            advance;
	logic            fire;
	logic            s_accept;
	logic signed [15:0] core_drive;
	logic            core_computed;

	logic            m_valid_q;
	logic [15:0]     m_drive_q;
	logic            m_computed_q;

	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// output register free or being emptied this cycle
	assign advance       = !m_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_accept)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.func         <= s_axis_tuser;
			item_s1.measured     <= s_axis_tdata[15:0];
			item_s1.setpoint     <= s_axis_tdata[31:16];
			item_s1.auto_request <= s_axis_tdata[32];
		end
	end

	// controller state and the whole step lives here
	pidc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (fire),
		.item     (item_s1),
		.drive    (core_drive),
		.computed (core_computed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (advance)
			m_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_drive_q    <= core_drive;
			m_computed_q <= core_computed;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_drive_q;
	assign m_axis_tuser  = m_computed_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_PERIOD   = 12;
	// limit sized several times over the slowest legal run of roughly 900 words
	localparam int CYCLE_LIMIT  = 600000;
	localparam int TOTAL_WORDS  = 850;
	localparam int PRINT_CAP    = 200;
	// index 7 is not a register, writes to it must be dropped
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// one expected output word
	typedef struct packed {
		logic signed [15:0] drive;
		logic               computed;
	} drive_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // measured[15:0], setpoint[31:16], auto_request[32], zero pad
	logic        s_axis_tuser = 1'b0; // func

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // drive[15:0]
	logic        m_axis_tuser;        // computed

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pid_controller_step i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// shadow copy of the register file, reset values
	logic [15:0]        kp_reg     = pidc_pkg::PROP_GAIN_RST;
	logic [15:0]        ki_reg     = '0;
	logic [15:0]        kd_reg     = '0;
	logic signed [15:0] lim_lo     = '0;
	logic signed [15:0] lim_hi     = pidc_pkg::OUT_MAX_RST;
	logic               p_on_meas  = 1'b0;
	logic               reverse_on = 1'b0;

	// shadow controller state
	logic signed [15:0] integ_q88  = '0;
	logic signed [15:0] last_meas  = '0;
	logic signed [15:0] last_drive = '0;
	logic               auto_mode  = 1'b0;

	drive_word_t expected_drive[$];
	int          errors = 0;
	int          sent_words = 0;     // words accepted by the block so far
	bit          no_idle = 1'b0;     // stretches with both sides running flat out
	int          stall_left = 0;

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// clamp with the inverted-limits rule: upper limit wins
	function automatic logic signed [15:0] clamp_q88(longint v);
		longint lo;
		longint hi;
		lo = longint'(lim_lo);
		hi = longint'(lim_hi);
		if (v > hi)
			return lim_hi;
		if (v < lo)
			return lim_lo;
		return v[15:0];
	endfunction

	// q.16 to q8.8, round half up (arithmetic shift floors)
	function automatic longint round_half_up(longint x);
		return (x + 64'sd128) >>> 8;
	endfunction

	// advance the shadow controller by one accepted word and queue its output
	function automatic void step_controller(pidc_pkg::item_t it);
		drive_word_t w;
		longint kp;
		longint ki;
		longint kd;
		longint meas;
		longint err;
		longint din;
		longint acc;
		w = '0;
		if (it.func == pidc_pkg::FUNC_MODE) begin
			// bumpless transfer only on the manual to auto edge
			if (it.auto_request && !auto_mode)
				integ_q88 = clamp_q88(longint'(last_drive));
			auto_mode = it.auto_request;
		end else if (auto_mode) begin
			kp = longint'(kp_reg);
			ki = longint'(ki_reg);
			kd = longint'(kd_reg);
			if (reverse_on) begin
				kp = -kp;
				ki = -ki;
				kd = -kd;
			end
			meas = longint'($signed(it.measured));
			err  = longint'($signed(it.setpoint)) - meas;
			din  = meas - longint'(last_meas);
			// integral first, clamped for anti-windup
			acc = longint'(integ_q88) * 256 + ki * err;
			if (p_on_meas)
				acc -= kp * din;
			integ_q88 = clamp_q88(round_half_up(acc));
			// then the drive from the fresh integral
			acc = longint'(integ_q88) * 256 - kd * din;
			if (!p_on_meas)
				acc += kp * err;
			last_drive = clamp_q88(round_half_up(acc));
			last_meas  = it.measured;
			w.drive    = last_drive;
			w.computed = 1'b1;
		end
		// manual-mode samples still give a zero word
		expected_drive.push_back(w);
	endfunction

	function automatic pidc_pkg::item_t sample_word(logic [15:0] meas, logic [15:0] sp);
		pidc_pkg::item_t it;
		it.func         = pidc_pkg::FUNC_SAMPLE;
		it.measured     = meas;
		it.setpoint     = sp;
		it.auto_request = 1'($urandom_range(0, 1));   // don't care on samples
		return it;
	endfunction

	function automatic pidc_pkg::item_t mode_word(logic req);
		pidc_pkg::item_t it;
		it.func         = pidc_pkg::FUNC_MODE;
		it.measured     = 16'($urandom_range(0, 65535));   // ignored on mode words
		it.setpoint     = 16'($urandom_range(0, 65535));
		it.auto_request = req;
		return it;
	endfunction

	// send one word; valid is only dropped when a gap follows, so back-to-back
	// words keep tvalid high across the edge
	task automatic send_word(pidc_pkg::item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.func;
		s_axis_tdata  <= {7'd0, it.auto_request, it.setpoint, it.measured};
		do @(posedge clk); while (!s_axis_tready);
		step_controller(it);
		sent_words++;
	endtask

	// stop sending and wait until every expected word has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one config write; only called with the pipeline drained
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pidc_pkg::REG_PROP_GAIN:    kp_reg     = val;
			pidc_pkg::REG_INTEG_GAIN:   ki_reg     = val;
			pidc_pkg::REG_DERIV_GAIN:   kd_reg     = val;
			pidc_pkg::REG_OUT_MIN:      lim_lo     = val;
			pidc_pkg::REG_OUT_MAX:      lim_hi     = val;
			pidc_pkg::REG_PROP_ON_MEAS: p_on_meas  = val[0];
			pidc_pkg::REG_REVERSE:      reverse_on = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
			logic [15:0] lo, logic [15:0] hi, logic pom, logic rev);
		drain();
		write_reg(pidc_pkg::REG_PROP_GAIN, kp);
		write_reg(pidc_pkg::REG_INTEG_GAIN, ki);
		write_reg(pidc_pkg::REG_DERIV_GAIN, kd);
		write_reg(pidc_pkg::REG_OUT_MIN, lo);
		write_reg(pidc_pkg::REG_OUT_MAX, hi);
		write_reg(pidc_pkg::REG_PROP_ON_MEAS, {15'd0, pom});
		write_reg(pidc_pkg::REG_REVERSE, {15'd0, rev});
	endtask

	// manual mode, mode switching and bumpless reload with reset gains
	task automatic test_manual_and_mode();
		send_word(sample_word(16'h1234, 16'h0100));   // manual: zero word, state kept
		send_word(mode_word(1'b0));                   // manual request while manual
		send_word(sample_word(16'h8000, 16'h7fff));
		send_word(mode_word(1'b1));                   // reload integral from drive 0
		send_word(sample_word(16'h0000, 16'h0100));
		send_word(sample_word(16'h8000, 16'h7fff));   // saturates high
		send_word(sample_word(16'h7fff, 16'h8000));   // saturates low
		send_word(mode_word(1'b1));                   // already auto: no reload
		send_word(sample_word(16'h0100, 16'h0300));
		send_word(mode_word(1'b0));
		send_word(sample_word(16'h4000, 16'h0000));   // ignored in manual
		send_word(mode_word(1'b1));                   // reload from last drive
		send_word(sample_word(16'h0100, 16'h0100));
	endtask

	// gain and limit extremes, rounding halves, inverted and collapsed limits
	task automatic test_register_extremes();
		apply_settings(16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 1'b0, 1'b0);
		send_word(sample_word(16'h8000, 16'h7fff));
		send_word(sample_word(16'h7fff, 16'h8000));
		send_word(sample_word(16'h0000, 16'h0000));
		apply_settings(16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 1'b1, 1'b1);
		send_word(sample_word(16'h7fff, 16'h0000));
		send_word(sample_word(16'h8000, 16'hffff));
		// half-lsb products land exactly on the rounding boundary
		apply_settings(16'h0080, 16'h0080, 16'h0080, 16'h8000, 16'h7fff, 1'b0, 1'b0);
		send_word(sample_word(16'h0000, 16'h0001));
		send_word(sample_word(16'h0001, 16'h0000));
		send_word(sample_word(16'h0000, 16'hffff));
		// inverted limits: upper limit takes precedence
		apply_settings(16'h0100, 16'h0040, 16'h0000, 16'h1000, 16'hf000, 1'b0, 1'b0);
		send_word(sample_word(16'h0000, 16'h2000));
		send_word(sample_word(16'h2000, 16'h0000));
		// write to a hole in the register map must change nothing
		drain();
		write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		send_word(sample_word(16'h0000, 16'h0800));
		// collapsed limits
		apply_settings(16'h0200, 16'h0100, 16'h0100, 16'h0300, 16'h0300, 1'b1, 1'b0);
		send_word(sample_word(16'h0100, 16'h0500));
		send_word(mode_word(1'b0));
		send_word(mode_word(1'b1));
		send_word(sample_word(16'hff00, 16'h0000));
	endtask

	function automatic logic [15:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hffff;
		if (r < 6)
			return 16'($urandom_range(0, 512));
		if (r < 9)
			return 16'($urandom_range(0, 4096));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic random_settings();
		logic [15:0] lo;
		logic [15:0] hi;
		int          r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			lo = 16'h8000;
			hi = 16'h7fff;
		end else if (r == 1) begin
			// inverted pair
			hi = 16'h0000 - 16'($urandom_range(0, 16384));
			lo = 16'($urandom_range(1, 16384));
		end else if (r == 2) begin
			lo = 16'($urandom_range(0, 65535));
			hi = lo;
		end else begin
			lo = 16'h0000 - 16'($urandom_range(0, 16384));
			hi = 16'($urandom_range(0, 16384));
		end
		apply_settings(pick_gain(), pick_gain(), pick_gain(), lo, hi,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	function automatic pidc_pkg::item_t random_sample();
		logic [15:0] sp;
		logic [15:0] meas;
		int          r;
		r = $urandom_range(0, 9);
		sp = 16'($urandom_range(0, 65535));
		if (r < 3) begin
			meas = 16'($urandom_range(0, 65535));
		end else if (r == 3) begin
			case ($urandom_range(0, 3))
				0: meas = 16'h8000;
				1: meas = 16'h7fff;
				2: meas = 16'h0000;
				default: meas = 16'hffff;
			endcase
			sp = ~meas;
		end else begin
			// near the setpoint, where the loop stays off the clamps
			meas = sp + 16'($urandom_range(0, 2048)) - 16'd1024;
		end
		return sample_word(meas, sp);
	endfunction

	// phases of random settings, each mostly auto-mode samples with a few
	// mode changes and one full drain halfway through
	task automatic test_random_control();
		int phase;
		int n;
		int r;
		phase = 0;
		while (sent_words < TOTAL_WORDS) begin
			drain();
			no_idle = (phase % 4 == 3);
			random_settings();
			if ($urandom_range(0, 4) != 0)
				send_word(mode_word(1'b1));
			for (n = 0; n < 85 && sent_words < TOTAL_WORDS; n++) begin
				if (n == 40)
					drain();
				r = $urandom_range(0, 99);
				if (r < 3)
					send_word(mode_word(1'b0));
				else if (r < 7)
					send_word(mode_word(1'b1));
				else
					send_word(random_sample());
			end
			phase++;
		end
		no_idle = 1'b0;
	endtask

	// receiver: random stalls, none while no_idle is set
	always @(posedge clk) begin
		if (no_idle) begin
			m_axis_tready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left = pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare every accepted output word against the oldest expectation
	always @(posedge clk) begin : check_drive
		drive_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_drive.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: unexpected word, expected none, actual drive %h computed %b",
						$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = expected_drive.pop_front();
				if (m_axis_tdata !== want.drive) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display("%0t: drive mismatch, expected %h actual %h",
							$time, want.drive, m_axis_tdata);
				end
				if (m_axis_tuser !== want.computed) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display("%0t: computed mismatch, expected %b actual %b",
							$time, want.computed, m_axis_tuser);
				end
			end
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_manual_and_mode();
		test_register_extremes();
		test_random_control();
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && expected_drive.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
